>>> hdl/awmc_pkg.sv
// shared types, constants and register codes for the window motion classifier
`timescale 1ns / 1ps
`default_nettype none

package awmc_pkg;

    localparam int WINDOW_DEFAULT = 16;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 20;
    localparam int SQ_W     = 32;
    localparam int ROOT_W   = 16;
    localparam int REM_W    = 18;

    // byte address of register i is 4*i, five registers
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int INDEX_W = 3;

    localparam logic [INDEX_W-1:0] REG_MAG_HIGH = 3'd0;
    localparam logic [INDEX_W-1:0] REG_MAG_LOW  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_X_HIGH   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_X_LOW    = 3'd3;
    localparam logic [INDEX_W-1:0] REG_X_NEG    = 3'd4;

    // sequencer step counts
    localparam int STEP_W     = 4;
    localparam int SQR_STEPS  = 3;
    localparam int ROOT_STEPS = 16;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [SUM_W-1:0] LEN_MAX = 20'hFFFFF;
    localparam logic [SUM_W-1:0] X_MAX   = 20'h7FFFF;
    localparam logic [SUM_W-1:0] X_MIN   = 20'h80000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic                    flag_high;
        logic                    flag_low;
        logic [SUM_W-1:0]        length_sum;
        logic signed [SUM_W-1:0] x_total;
    } result_t;

    typedef struct packed {
        logic [SUM_W-1:0]        mag_high_limit;
        logic [SUM_W-1:0]        mag_low_limit;
        logic signed [SUM_W-1:0] x_high_limit;
        logic [SUM_W-1:0]        x_low_limit;
        logic signed [SUM_W-1:0] x_negative_limit;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       sqr_en;
        logic [1:0] axis;
        logic       root_en;
        logic       accum_en;
        logic       emit;
    } dp_cmd_t;

    typedef struct packed {
        logic window_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/accel_window_motion_classifier.sv
// top level: limit registers on the bus port, sequencer and datapath
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+-------------------------
//  sample   | in        | sample_valid / sample_stall   | accel_x, accel_y, accel_z
//  result   | out       | result_valid / result_stall   | flags, length_sum, x_total
//  bus      | in        | psel, penable, pwrite, pready | five 20-bit limits
//
// each item is loaded, squared on its three axes in turn through the single shared squarer,
// taken through 16 square-root steps at two bits each and accumulated before the next can be
// taken; the last item of a window also loads the result register.
// a stalled result register holds the block only at the end of a window.
// reset clears the sums, the sample count, both flags and all limits.
`timescale 1ns / 1ps
`default_nettype none

module accel_window_motion_classifier
#(
    parameter int WINDOW = awmc_pkg::WINDOW_DEFAULT
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                sample_valid,
    output logic                               sample_stall,
    input  awmc_pkg::sample_t                  sample,
    output logic                               result_valid,
    input  wire                                result_stall,
    output awmc_pkg::result_t                  result,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [awmc_pkg::ADDR_W-1:0]        paddr,
    input  wire  [awmc_pkg::DATA_W-1:0]        pwdata,
    output logic [awmc_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    awmc_pkg::cfg_t                      cfg_reg;
    awmc_pkg::dp_cmd_t                   cmd;
    awmc_pkg::dp_stat_t                  stat;
    logic [awmc_pkg::INDEX_W-1:0]        reg_index;
    logic                                wr_en;
    logic [awmc_pkg::SUM_W-1:0]          wr_value;

    assign pready    = 1'b1;
    assign reg_index = paddr[awmc_pkg::ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign wr_value  = pwdata[awmc_pkg::SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                awmc_pkg::REG_MAG_HIGH: cfg_reg.mag_high_limit   <= wr_value;
                awmc_pkg::REG_MAG_LOW:  cfg_reg.mag_low_limit    <= wr_value;
                awmc_pkg::REG_X_HIGH:   cfg_reg.x_high_limit     <= wr_value;
                awmc_pkg::REG_X_LOW:    cfg_reg.x_low_limit      <= wr_value;
                awmc_pkg::REG_X_NEG:    cfg_reg.x_negative_limit <= wr_value;
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            awmc_pkg::REG_MAG_HIGH: prdata = awmc_pkg::DATA_W'(cfg_reg.mag_high_limit);
            awmc_pkg::REG_MAG_LOW:  prdata = awmc_pkg::DATA_W'(cfg_reg.mag_low_limit);
            awmc_pkg::REG_X_HIGH:   prdata = awmc_pkg::DATA_W'(unsigned'(cfg_reg.x_high_limit));
            awmc_pkg::REG_X_LOW:    prdata = awmc_pkg::DATA_W'(cfg_reg.x_low_limit);
            awmc_pkg::REG_X_NEG:
                prdata = awmc_pkg::DATA_W'(unsigned'(cfg_reg.x_negative_limit));
            default:                prdata = '0;
        endcase
    end

    awmc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .cmd          (cmd),
        .stat         (stat)
    );

    awmc_datapath
    #(
        .WINDOW (WINDOW)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> hdl/awmc_ctrl.sv
// sequencer: squares, square-root steps, accumulate, window result
`timescale 1ns / 1ps
`default_nettype none

module awmc_ctrl
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  sample_valid,
    output logic                 sample_stall,
    output awmc_pkg::dp_cmd_t    cmd,
    input  awmc_pkg::dp_stat_t   stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQR   = 3'd1;
    localparam logic [2:0] ST_ROOT  = 3'd2;
    localparam logic [2:0] ST_ACCUM = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [awmc_pkg::STEP_W-1:0]   step_reg;
    logic [awmc_pkg::STEP_W-1:0]   step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQR;
                    step_next  = '0;
                end
            end
            ST_SQR:
            begin
                cmd.sqr_en = 1'b1;
                cmd.axis   = step_reg[1:0];
                if (step_reg == awmc_pkg::STEP_W'(awmc_pkg::SQR_STEPS - 1))
                begin
                    state_next = ST_ROOT;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_ROOT:
            begin
                cmd.root_en = 1'b1;
                if (step_reg == awmc_pkg::STEP_W'(awmc_pkg::ROOT_STEPS - 1))
                begin
                    state_next = ST_ACCUM;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_ACCUM:
            begin
                cmd.accum_en = 1'b1;
                state_next   = stat.window_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                // hold until the output register can take the window result
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/awmc_datapath.sv
// datapath: shared squarer, two-bit-per-step square root, window sums, output register
`timescale 1ns / 1ps
`default_nettype none

module awmc_datapath
#(
    parameter int WINDOW = awmc_pkg::WINDOW_DEFAULT
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  awmc_pkg::sample_t    sample,
    input  awmc_pkg::cfg_t       cfg,
    input  awmc_pkg::dp_cmd_t    cmd,
    output awmc_pkg::dp_stat_t   stat,
    output logic                 result_valid,
    input  wire                  result_stall,
    output awmc_pkg::result_t    result
);

    localparam int CNT_W = $clog2(WINDOW);

    awmc_pkg::sample_t                       sample_reg;
    logic signed [awmc_pkg::SAMPLE_W-1:0]    operand;
    logic signed [awmc_pkg::SQ_W-1:0]        square;
    logic [awmc_pkg::SQ_W-1:0]               sq_reg;
    logic [awmc_pkg::REM_W-1:0]              rem_reg;
    logic [awmc_pkg::ROOT_W-1:0]             root_reg;
    logic [awmc_pkg::REM_W+1:0]              rem_shift;
    logic [awmc_pkg::REM_W+1:0]              trial;

    logic [CNT_W-1:0]                        count_reg;
    logic [awmc_pkg::SUM_W-1:0]              len_acc_reg;
    logic signed [awmc_pkg::SUM_W-1:0]       x_acc_reg;
    logic [awmc_pkg::SUM_W:0]                len_wide;
    logic signed [awmc_pkg::SUM_W:0]         x_wide;
    logic [awmc_pkg::SUM_W-1:0]              len_next;
    logic signed [awmc_pkg::SUM_W-1:0]       x_next;

    logic [awmc_pkg::SUM_W:0]                x_abs;
    logic                                    len_above;
    logic                                    len_below;
    logic                                    fwd_hit;
    logic                                    rest_hit;
    logic                                    back_hit;
    logic                                    status_high_reg;
    logic                                    status_low_reg;
    logic                                    status_high_next;
    logic                                    status_low_next;

    logic                                    out_valid_reg;
    awmc_pkg::result_t                       out_reg;

    // squarer operand
    always_comb
    begin
        unique case (cmd.axis)
            awmc_pkg::AXIS_X: operand = sample_reg.accel_x;
            awmc_pkg::AXIS_Y: operand = sample_reg.accel_y;
            awmc_pkg::AXIS_Z: operand = sample_reg.accel_z;
            default:          operand = sample_reg.accel_z;
        endcase
    end

    assign square    = operand * operand;
    assign rem_shift = {rem_reg, sq_reg[awmc_pkg::SQ_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};

    // payload: sample, sum of squares, root recurrence
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            sq_reg     <= '0;
            rem_reg    <= '0;
            root_reg   <= '0;
        end
        else if (cmd.sqr_en)
        begin
            sq_reg <= sq_reg + awmc_pkg::SQ_W'(unsigned'(square));
        end
        else if (cmd.root_en)
        begin
            sq_reg <= {sq_reg[awmc_pkg::SQ_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_reg  <= awmc_pkg::REM_W'(rem_shift - trial);
                root_reg <= {root_reg[awmc_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= awmc_pkg::REM_W'(rem_shift);
                root_reg <= {root_reg[awmc_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // saturating window sums
    always_comb
    begin
        len_wide = {1'b0, len_acc_reg}
                 + {{(awmc_pkg::SUM_W + 1 - awmc_pkg::ROOT_W){1'b0}}, root_reg};
        x_wide   = {x_acc_reg[awmc_pkg::SUM_W-1], x_acc_reg}
                 + (awmc_pkg::SUM_W + 1)'(sample_reg.accel_x);
        len_next = len_wide[awmc_pkg::SUM_W] ? awmc_pkg::LEN_MAX
                                             : len_wide[awmc_pkg::SUM_W-1:0];
        if (x_wide[awmc_pkg::SUM_W] != x_wide[awmc_pkg::SUM_W-1])
            x_next = x_wide[awmc_pkg::SUM_W] ? awmc_pkg::X_MIN : awmc_pkg::X_MAX;
        else
            x_next = x_wide[awmc_pkg::SUM_W-1:0];
    end

    assign stat.window_last = (count_reg == CNT_W'(WINDOW - 1));
    assign stat.out_free    = !out_valid_reg || !result_stall;

    // classification, first match wins
    always_comb
    begin
        x_abs = x_acc_reg[awmc_pkg::SUM_W-1]
              ? (awmc_pkg::SUM_W + 1)'(-{x_acc_reg[awmc_pkg::SUM_W-1], x_acc_reg})
              : {1'b0, x_acc_reg};
        len_above = len_acc_reg > cfg.mag_high_limit;
        len_below = len_acc_reg < cfg.mag_low_limit;
        fwd_hit   = len_above && (x_acc_reg > cfg.x_high_limit);
        rest_hit  = len_below && (x_abs < {1'b0, cfg.x_low_limit});
        back_hit  = len_above && (x_acc_reg < cfg.x_negative_limit);
        status_high_next = status_high_reg;
        status_low_next  = status_low_reg;
        if (fwd_hit)
        begin
            status_high_next = 1'b0;
            status_low_next  = 1'b1;
        end
        else if (rest_hit)
        begin
            status_high_next = 1'b1;
            status_low_next  = 1'b0;
        end
        else if (back_hit)
        begin
            status_high_next = 1'b1;
            status_low_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            len_acc_reg     <= '0;
            x_acc_reg       <= '0;
            status_high_reg <= 1'b0;
            status_low_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.accum_en)
            begin
                len_acc_reg <= len_next;
                x_acc_reg   <= x_next;
                count_reg   <= stat.window_last ? '0 : count_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                status_high_reg <= status_high_next;
                status_low_reg  <= status_low_next;
                len_acc_reg     <= '0;
                x_acc_reg       <= '0;
                out_valid_reg   <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.flag_high  <= status_high_next;
            out_reg.flag_low   <= status_low_next;
            out_reg.length_sum <= len_acc_reg;
            out_reg.x_total    <= x_acc_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// self-checking testbench for the accelerometer window motion classifier
`timescale 1ns / 1ps

module tb_top;

    localparam int WIN          = awmc_pkg::WINDOW_DEFAULT;
    localparam int SETTLE_TICKS = 30;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LEN_TOP      = 1048575;
    localparam int XSUM_TOP     = 524287;
    localparam int XSUM_BOTTOM  = -524288;
    localparam logic [awmc_pkg::INDEX_W-1:0] REG_LAST = {awmc_pkg::INDEX_W{1'b1}};

    logic                          clk;
    logic                          rst_n;
    logic                          sample_valid;
    logic                          sample_stall;
    awmc_pkg::sample_t             sample;
    logic                          result_valid;
    logic                          result_stall;
    awmc_pkg::result_t             result;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [awmc_pkg::ADDR_W-1:0]   paddr;
    logic [awmc_pkg::DATA_W-1:0]   pwdata;
    logic [awmc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // predictor copy of the limits and the window state
    logic [awmc_pkg::SUM_W-1:0]        lim_mag_high;
    logic [awmc_pkg::SUM_W-1:0]        lim_mag_low;
    logic signed [awmc_pkg::SUM_W-1:0] lim_x_high;
    logic [awmc_pkg::SUM_W-1:0]        lim_x_low;
    logic signed [awmc_pkg::SUM_W-1:0] lim_x_neg;
    int                                window_fill;
    int                                len_acc;
    int                                x_acc;
    logic                              flag_hi_q;
    logic                              flag_lo_q;

    awmc_pkg::result_t pending_windows[$];
    int                fail_count;
    int                cycle_count;
    int                sender_idle_pct;
    int                receiver_stall_pct;

    accel_window_motion_classifier i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver back-pressure, redrawn every cycle
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall = ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    function automatic int rand_span(input int lo, input int hi);
        int off;
        off = $urandom_range(0, hi - lo);
        return lo + off;
    endfunction

    function automatic awmc_pkg::sample_t vec(input int x, input int y, input int z);
        awmc_pkg::sample_t s;
        s.accel_x = x[awmc_pkg::SAMPLE_W-1:0];
        s.accel_y = y[awmc_pkg::SAMPLE_W-1:0];
        s.accel_z = z[awmc_pkg::SAMPLE_W-1:0];
        return s;
    endfunction

    // folds one sample into the window; returns 1 when the window closes
    function automatic bit fold_sample(input awmc_pkg::sample_t s,
                                       output awmc_pkg::result_t r);
        int     sx, sy, sz;
        longint sq;
        longint cand;
        int     root;
        int     mh, ml, xh, xl, xn, xabs;
        sx = s.accel_x;
        sy = s.accel_y;
        sz = s.accel_z;
        sq = longint'(sx) * sx + longint'(sy) * sy + longint'(sz) * sz;
        root = 0;
        for (int b = awmc_pkg::ROOT_W - 1; b >= 0; b--)
        begin
            cand = root + (longint'(1) << b);
            if (cand * cand <= sq)
                root = int'(cand);
        end
        len_acc = len_acc + root;
        if (len_acc > LEN_TOP)
            len_acc = LEN_TOP;
        x_acc = x_acc + sx;
        if (x_acc > XSUM_TOP)
            x_acc = XSUM_TOP;
        if (x_acc < XSUM_BOTTOM)
            x_acc = XSUM_BOTTOM;
        r = '0;
        window_fill++;
        if (window_fill < WIN)
            return 1'b0;
        window_fill = 0;
        mh = lim_mag_high;
        ml = lim_mag_low;
        xh = lim_x_high;
        xl = lim_x_low;
        xn = lim_x_neg;
        xabs = (x_acc < 0) ? -x_acc : x_acc;
        // priority: forward, at rest, backward, else hold
        if (len_acc > mh && x_acc > xh)
        begin
            flag_hi_q = 1'b0;
            flag_lo_q = 1'b1;
        end
        else if (len_acc < ml && xabs < xl)
        begin
            flag_hi_q = 1'b1;
            flag_lo_q = 1'b0;
        end
        else if (len_acc > mh && x_acc < xn)
        begin
            flag_hi_q = 1'b1;
            flag_lo_q = 1'b1;
        end
        r.flag_high  = flag_hi_q;
        r.flag_low   = flag_lo_q;
        r.length_sum = len_acc[awmc_pkg::SUM_W-1:0];
        r.x_total    = x_acc[awmc_pkg::SUM_W-1:0];
        len_acc = 0;
        x_acc = 0;
        return 1'b1;
    endfunction

    task automatic send_sample(input awmc_pkg::sample_t s);
        awmc_pkg::result_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            sample_valid = 1'b0;
            sample = vec($urandom(), $urandom(), $urandom());
            @(negedge clk);
        end
        sample = s;
        sample_valid = 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        if (fold_sample(s, r))
            pending_windows.push_back(r);
    endtask

    // waits until every window result is in and the block has gone quiet
    task automatic settle();
        @(negedge clk);
        sample_valid = 1'b0;
        while (pending_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // junk in the upper bits must be dropped by the block
    task automatic write_limit(input logic [awmc_pkg::INDEX_W-1:0] idx, input int val);
        logic [awmc_pkg::DATA_W-1:0] d;
        d = $urandom();
        d[awmc_pkg::SUM_W-1:0] = val[awmc_pkg::SUM_W-1:0];
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = d;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            awmc_pkg::REG_MAG_HIGH: lim_mag_high = d[awmc_pkg::SUM_W-1:0];
            awmc_pkg::REG_MAG_LOW:  lim_mag_low  = d[awmc_pkg::SUM_W-1:0];
            awmc_pkg::REG_X_HIGH:   lim_x_high   = d[awmc_pkg::SUM_W-1:0];
            awmc_pkg::REG_X_LOW:    lim_x_low    = d[awmc_pkg::SUM_W-1:0];
            awmc_pkg::REG_X_NEG:    lim_x_neg    = d[awmc_pkg::SUM_W-1:0];
            default:                ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_all_limits(input int mh, input int ml, input int xh, input int xl,
                                    input int xn);
        write_limit(awmc_pkg::REG_MAG_HIGH, mh);
        write_limit(awmc_pkg::REG_MAG_LOW, ml);
        write_limit(awmc_pkg::REG_X_HIGH, xh);
        write_limit(awmc_pkg::REG_X_LOW, xl);
        write_limit(awmc_pkg::REG_X_NEG, xn);
    endtask

    always @(posedge clk)
    begin
        awmc_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_windows.size() == 0)
            begin
                $error("unexpected result item: length_sum %0d x_total %0d",
                       result.length_sum, result.x_total);
                fail_count++;
            end
            else
            begin
                want = pending_windows.pop_front();
                if (result.flag_high !== want.flag_high)
                begin
                    $error("flag_high: expected %0b, actual %0b", want.flag_high,
                           result.flag_high);
                    fail_count++;
                end
                if (result.flag_low !== want.flag_low)
                begin
                    $error("flag_low: expected %0b, actual %0b", want.flag_low,
                           result.flag_low);
                    fail_count++;
                end
                if (result.length_sum !== want.length_sum)
                begin
                    $error("length_sum: expected %0d, actual %0d", want.length_sum,
                           result.length_sum);
                    fail_count++;
                end
                if (result.x_total !== want.x_total)
                begin
                    $error("x_total: expected %0d, actual %0d", want.x_total,
                           result.x_total);
                    fail_count++;
                end
            end
        end
    end

    // full-scale vectors with the limits still at their reset values
    task automatic test_input_extremes();
        for (int i = 0; i < WIN; i++)
        begin
            case (i % 4)
                0: send_sample(vec(32767, 32767, 32767));
                1: send_sample(vec(-32768, -32768, -32768));
                2: send_sample(vec(0, 0, 0));
                default: send_sample(vec(-32768, 32767, -1));
            endcase
        end
        settle();
    endtask

    task automatic test_classes();
        // forward with zero limits
        for (int i = 0; i < WIN; i++)
            send_sample(vec(20000, -3000, 500));
        settle();
        // at rest, forward blocked by the top x limit
        write_all_limits(0, 1000, XSUM_TOP, 100, 0);
        for (int i = 0; i < WIN; i++)
            send_sample(vec((i % 2 == 0) ? -2 : 2, 3, -4));
        settle();
        // backward
        for (int i = 0; i < WIN; i++)
            send_sample(vec(-25000, 100, -100));
        settle();
        // zero vectors against a zero low limit: strict compare, flags hold
        write_limit(awmc_pkg::REG_MAG_LOW, 0);
        for (int i = 0; i < WIN; i++)
            send_sample(vec(0, 0, 0));
        settle();
    endtask

    // unmapped addresses are ignored, mapped ones keep only 20 bits
    task automatic test_register_decode();
        for (int idx = awmc_pkg::REG_X_NEG + 1; idx <= REG_LAST; idx++)
            write_limit(idx[awmc_pkg::INDEX_W-1:0], $urandom());
        write_all_limits(rand_span(0, 600000), rand_span(0, 400000),
                         rand_span(-300000, 300000), rand_span(0, 524288),
                         rand_span(-300000, 300000));
        for (int idx = awmc_pkg::REG_X_NEG + 1; idx <= REG_LAST; idx++)
            write_limit(idx[awmc_pkg::INDEX_W-1:0], $urandom());
        for (int i = 0; i < WIN; i++)
            send_sample(vec($urandom(), $urandom(), $urandom()));
        settle();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int mode;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_all_limits(LEN_TOP, LEN_TOP, XSUM_BOTTOM, XSUM_TOP + 1, XSUM_TOP);
                1: write_all_limits(0, 0, XSUM_BOTTOM, 0, XSUM_BOTTOM);
                default: write_all_limits(rand_span(0, 700000), rand_span(0, 400000),
                                          rand_span(-300000, 300000), rand_span(0, 524288),
                                          rand_span(-300000, 300000));
            endcase
            for (int w = 0; w < 10; w++)
            begin
                mode = $urandom_range(0, 4);
                for (int i = 0; i < WIN; i++)
                begin
                    case (mode)
                        0: send_sample(vec($urandom(), $urandom(), $urandom()));
                        1: send_sample(vec(rand_span(-32, 32), rand_span(-32, 32),
                                           rand_span(-32, 32)));
                        2: send_sample(vec(rand_span(8192, 32767), rand_span(-8192, 8192),
                                           rand_span(-8192, 8192)));
                        3: send_sample(vec(rand_span(-32768, -8192), rand_span(-8192, 8192),
                                           rand_span(-8192, 8192)));
                        default: send_sample(vec(rand_span(-4096, 4096),
                                                 rand_span(-4096, 4096),
                                                 rand_span(-4096, 4096)));
                    endcase
                end
            end
            settle();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        lim_mag_high = '0;
        lim_mag_low = '0;
        lim_x_high = '0;
        lim_x_low = '0;
        lim_x_neg = '0;
        window_fill = 0;
        len_acc = 0;
        x_acc = 0;
        flag_hi_q = 1'b0;
        flag_lo_q = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_input_extremes();
        test_classes();
        test_register_decode();
        test_random_traffic(32, 70);
        test_random_traffic(70, 32);
        test_random_traffic(0, 0);
        settle();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
